[design/ptngs_pkg.sv]
// ============================================================================
// ptngs_pkg
// Shared types and constants of the per-track note gate scheduler.
// ============================================================================
package ptngs_pkg;

  // Track field width and the largest store the track field can address
  localparam int unsigned TrackW   = 4;
  localparam int unsigned StoreMax = 16;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_PULSE = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Message kinds on the result channel
  typedef enum logic [1:0] {
    KIND_ON     = 2'd0,
    KIND_OFF    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROC  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  // One track entry as kept in the store (37 bits)
  typedef struct packed {
    logic [6:0]  note;
    logic [4:0]  channel;
    logic [6:0]  velocity;
    logic [15:0] life;
    logic        hold;
    logic        playing;
  } entry_t;

  // One outgoing message
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  track;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [4:0]  channel;
    logic        playing;
  } result_t;

  // Write port of the entry store
  typedef struct packed {
    logic              en;
    logic [TrackW-1:0] addr;
    entry_t            data;
  } store_wr_t;

endpackage

[design/ptngs_store.sv]
// ============================================================================
// ptngs_store
// Track entry memory: one write and one registered read per cycle. Per-entry
// valid bits make a never-written entry read as all zero after reset.
// ============================================================================
module ptngs_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptngs_pkg::store_wr_t              wr_i,
  input  logic [ptngs_pkg::TrackW-1:0]      raddr_i,
  output ptngs_pkg::entry_t                 rdata_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ptngs_pkg::entry_t mem_q [DEPTH];
  ptngs_pkg::entry_t rdata_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rvld_q;

  // Write entry and read addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i[AddrW-1:0]];
  end

  // Track which entries hold written data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr[AddrW-1:0]] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i[AddrW-1:0]];
    end
  end

  // Unwritten entries read as the cleared value
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[design/per_track_note_gate_scheduler_top.sv]
// ============================================================================
// per_track_note_gate_scheduler_top
// Per-track note entry store that gates note-on and note-off messages with a
// pulse clock, replaces entries on add and reports playing flags on query.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o | opcode, track, note fields
//   out     | output    | out_valid_o / out_ready_i | kind, track, note, flag, last
//
// An add or a query on a valid track passes through accept with store read,
// update and flush. An out-of-range query goes from accept to flush; other
// dropped items end at accept. A pulse reads, updates and writes back all
// min(TRACKS,16) entries one per cycle, unless stalled, via store read/write ports.
// Reset clears all entries at once through per-entry valid bits.
// The walk stalls while a new message meets full pending and output registers.
// ============================================================================
module per_track_note_gate_scheduler_top #(
  parameter int unsigned TRACKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  track_i,
  input  logic [6:0]  root_note_i,
  input  logic [4:0]  midi_channel_i,
  input  logic [6:0]  velocity_i,
  input  logic [15:0] pulse_life_i,
  input  logic        hold_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  out_track_o,
  output logic [6:0]  out_note_o,
  output logic [6:0]  out_velocity_o,
  output logic [4:0]  out_channel_o,
  output logic        is_playing_o,
  output logic        last_o
);

  localparam int unsigned Depth = (TRACKS < ptngs_pkg::StoreMax) ? TRACKS
                                                                  : ptngs_pkg::StoreMax;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  ptngs_pkg::state_e    state_q, state_d;
  logic [AddrW-1:0]     idx_q, idx_d, idx_next;
  ptngs_pkg::opcode_e   op_q;
  ptngs_pkg::entry_t    new_q;
  ptngs_pkg::entry_t    cur;
  ptngs_pkg::entry_t    wr_entry;
  ptngs_pkg::store_wr_t wr;
  logic [ptngs_pkg::TrackW-1:0] raddr;

  ptngs_pkg::result_t   res, pend_q, pend_d, out_q, out_d;
  logic                 pend_v_q, pend_v_d, out_v_q, out_v_d, out_last_q, out_last_d;
  logic                 has_res, wr_req, stall, walk_end, out_free, trk_ok, in_xfer;

  // Entry store
  ptngs_store #(
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (cur)
  );

  assign in_ready_o = (state_q == ptngs_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign trk_ok     = ({1'b0, track_i} < 5'(Depth));
  assign out_free   = !out_v_q || out_ready_i;
  assign idx_next   = idx_q + AddrW'(1);
  assign walk_end   = (op_q != ptngs_pkg::OP_PULSE) || (idx_q == LastIdx);

  // Latch the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= ptngs_pkg::OP_NONE;
    end else if (in_xfer) begin
      op_q <= ptngs_pkg::opcode_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      new_q.note     <= root_note_i;
      new_q.channel  <= midi_channel_i;
      new_q.velocity <= velocity_i;
      new_q.life     <= pulse_life_i;
      new_q.hold     <= hold_i;
      new_q.playing  <= 1'b0;
    end
  end

  // Modify the entry read from the store and form its message
  always_comb begin
    has_res       = 1'b0;
    wr_req        = 1'b0;
    wr_entry      = cur;
    res.kind      = ptngs_pkg::KIND_STATUS;
    res.track     = 4'(idx_q);
    res.note      = cur.note;
    res.velocity  = cur.velocity;
    res.channel   = cur.channel;
    res.playing   = cur.playing;
    case (op_q)
      ptngs_pkg::OP_ADD: begin
        wr_req           = 1'b1;
        wr_entry         = new_q;
        wr_entry.playing = cur.playing && cur.hold;
        has_res          = cur.playing && !cur.hold;
        res.kind         = ptngs_pkg::KIND_OFF;
        res.playing      = 1'b0;
      end
      ptngs_pkg::OP_PULSE: begin
        wr_req = 1'b1;
        if (cur.life != '0) begin
          if (cur.playing) begin
            wr_entry.life = cur.life - 16'd1;
          end else begin
            wr_entry.playing = 1'b1;
            has_res          = 1'b1;
            res.kind         = ptngs_pkg::KIND_ON;
            res.playing      = 1'b1;
          end
        end else if (cur.playing) begin
          wr_entry.playing = 1'b0;
          has_res          = 1'b1;
          res.kind         = ptngs_pkg::KIND_OFF;
          res.playing      = 1'b0;
        end
      end
      ptngs_pkg::OP_QUERY: begin
        has_res = 1'b1;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // Hold the walk when a second message has nowhere to go
  assign stall = has_res && pend_v_q && !out_free;

  // Sequence items, drive store accesses and move messages toward the output
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    raddr      = 4'(idx_q);
    wr.en      = 1'b0;
    wr.addr    = 4'(idx_q);
    wr.data    = wr_entry;
    case (state_q)
      ptngs_pkg::S_IDLE: begin
        raddr = (opcode_i == ptngs_pkg::OP_PULSE) ? '0 : track_i;
        if (in_xfer) begin
          idx_d = track_i[AddrW-1:0];
          case (opcode_i)
            ptngs_pkg::OP_ADD: begin
              if (trk_ok) begin
                state_d = ptngs_pkg::S_PROC;
              end
            end
            ptngs_pkg::OP_PULSE: begin
              idx_d   = '0;
              state_d = ptngs_pkg::S_PROC;
            end
            ptngs_pkg::OP_QUERY: begin
              if (trk_ok) begin
                state_d = ptngs_pkg::S_PROC;
              end else begin
                pend_d       = '0;
                pend_d.kind  = ptngs_pkg::KIND_STATUS;
                pend_d.track = track_i;
                pend_v_d     = 1'b1;
                state_d      = ptngs_pkg::S_FLUSH;
              end
            end
            default: begin
              state_d = ptngs_pkg::S_IDLE;
            end
          endcase
        end
      end
      ptngs_pkg::S_PROC: begin
        if (!stall) begin
          wr.en = wr_req;
          if (has_res) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_d   = res;
            pend_v_d = 1'b1;
          end
          if (walk_end) begin
            state_d = ptngs_pkg::S_FLUSH;
          end else begin
            idx_d = idx_next;
            raddr = 4'(idx_next);
          end
        end
      end
      ptngs_pkg::S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ptngs_pkg::S_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ptngs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ptngs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptngs_pkg::S_IDLE;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Message registers
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_q.kind;
  assign out_track_o    = out_q.track;
  assign out_note_o     = out_q.note;
  assign out_velocity_o = out_q.velocity;
  assign out_channel_o  = out_q.channel;
  assign is_playing_o   = out_q.playing;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  // No message may wait in the pending stage once the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptngs_pkg::S_IDLE) |-> !pend_v_q)
    else $error("pending message left behind at idle");

  // The store is written only while an entry is being updated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ptngs_pkg::S_PROC))
    else $error("store write outside update state");

  // A flushed message appears at the output marked as final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptngs_pkg::S_FLUSH && pend_v_q && out_free) |=> (out_valid_o && last_o))
    else $error("final message not presented with last");

  // A new item is taken only with the output free of a non-final message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && out_valid_o) |-> last_o)
    else $error("item accepted while a walk message is still out");
`endif

endmodule
